### rtl/adaptive_step_size_controller_assert.svh
// Assertion macros used by the step size controller's control module
`ifndef ADAPTIVE_STEP_SIZE_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_STEP_SIZE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define ASSC_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// next-cycle implication
`define ASSC_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

### rtl/assc_pkg.sv
// Types, constants and tables of the step size controller
package assc_pkg;

   localparam int LOG_ITERATIONS = 24;
   localparam int HISTORY_DEPTH  = 3;
   localparam int HIST_IDX_W     = 2;
   localparam int ITER_W         = $clog2(LOG_ITERATIONS + 1);
   localparam int FRAC_W         = 48;
   localparam int FRAC_IDX_W     = 6;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX  = 2'd3;

   localparam logic [31:0] EXP_ONE_THIRD = 32'd1431655765;
   localparam logic [31:0] EXP_NEWEST    = 32'd1052266988;
   localparam logic [31:0] EXP_MIDDLE    = 32'd730144440;
   localparam logic [31:0] EXP_OLDEST    = 32'd214748365;
   localparam logic [31:0] SAFETY_FACTOR = 32'd3865470566;
   localparam logic [63:0] TOL_RESET     = 64'd281475;
   localparam logic [31:0] PID_START     = 32'd4;
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] GROWTH_BOUND  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd5;
   localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [63:0] error_value;
      logic [63:0] current_step;
      logic [31:0] steps_taken;
      logic [31:0] rejections;
   } req_type;

   typedef struct packed {
      logic [63:0] next_step;
      logic        hit_minimum;
      logic        hit_maximum;
      logic [31:0] minimum_hits;
      logic [31:0] maximum_hits;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_LOG_INIT, OP_NORM, OP_LOG_SQ, OP_TOL_SAVE,
      OP_TERM_LO, OP_TERM_HI, OP_EXP_INIT, OP_EXP_STEP, OP_PROD_LO,
      OP_PROD_HI, OP_SAFE_LO, OP_SAFE_HI, OP_SHIFT, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [1:0]        opnd;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   typedef struct packed {
      logic norm_done;
      logic use_pid;
   } sts_type;

   typedef logic [31:0] root_table_type [LOG_ITERATIONS+1];

   // repeated square roots of 2.0 in Q2.30
   function automatic root_table_type build_roots();
      root_table_type t;
      logic [63:0]    v;
      logic [63:0]    res;
      logic [63:0]    bt;
      int             k;
      int             j;
      t[0] = 32'h8000_0000;
      for (k = 1; k <= LOG_ITERATIONS; k++) begin
         v   = 64'(t[k-1]) << 30;
         res = 64'd0;
         bt  = 64'd1 << 62;
         for (j = 0; j < 32; j++) begin
            if (bt > v) bt = bt >> 2;
         end
         for (j = 0; j < 32; j++) begin
            if (bt != 64'd0) begin
               if (v >= res + bt) begin
                  v   = v - (res + bt);
                  res = (res >> 1) + bt;
               end else begin
                  res = res >> 1;
               end
               bt = bt >> 2;
            end
         end
         t[k] = res[31:0];
      end
      return t;
   endfunction

   localparam root_table_type ROOT_TABLE = build_roots();

endpackage

### rtl/adaptive_step_size_controller.sv
// Per item: log2 of the tolerance and of one error (proportional) or three errors (PID), LOG_ITERATIONS = 24.
// Each log2 loads, normalizes and squares once per fraction bit; exp2 and the scaling then follow.
// req_stall stays high after acceptance until the result is written; rsp_stall can hold that write.
// Items go through one at a time on the single shared 32x32 multiplier stepping log2, exp2 and the scaling.
// The next item is taken while the previous result waits in the output register.
// Synchronous reset clears control, config to defaults, error history and hit counters.
module adaptive_step_size_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  assc_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output assc_pkg::rsp_type              rsp_payload,
   input  logic                           csr_write_en,
   input  logic [assc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_wdata
);

   assc_pkg::cmd_type cmd;
   assc_pkg::sts_type sts;

   assc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   assc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_payload  (rsp_payload)
   );

endmodule

### rtl/assc_dp.sv
// Datapath: config registers, error history, log2/exp2 unit, bounding and hit counters
module assc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [assc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                     csr_wdata,
   input  assc_pkg::req_type               req_payload,
   input  assc_pkg::cmd_type               cmd,
   output assc_pkg::sts_type               sts,
   output assc_pkg::rsp_type               rsp_payload
);

   localparam int FRAC_SHIFT = assc_pkg::FRAC_W - assc_pkg::LOG_ITERATIONS;
   localparam int HIST_SEL_W = assc_pkg::HIST_IDX_W;

   function automatic logic [1:0] mod3_33(input logic [32:0] v);
      logic [33:0] w;
      logic [5:0]  s;
      logic [3:0]  t;
      logic [2:0]  u;
      int          i;
      w = {1'b0, v};
      s = 6'd0;
      for (i = 0; i < 17; i++) s = s + 6'(w[2*i +: 2]);
      t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
      u = 3'(t[3:2]) + 3'(t[1:0]);
      return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
   endfunction

   function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] t;
      t = 3'(a) + 3'(b);
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   logic        mode_ff;
   logic [63:0] tol_ff, min_ff, max_ff;
   logic [63:0] hist_ff [assc_pkg::HISTORY_DEPTH];
   logic [31:0] minc_ff, maxc_ff;
   logic [63:0] err_ff, step_ff;
   logic        pid_ff;
   logic [1:0]  r_ff;
   logic [63:0] xn_ff;
   logic [5:0]  sh_ff;
   logic [31:0] m_ff;
   logic [assc_pkg::LOG_ITERATIONS-1:0] fbits_ff;
   logic        zero_ff;
   logic signed [63:0] ltol_ff, e_ff;
   logic [63:0] pp_ff;
   logic [31:0] acc_ff;
   logic        over_ff;
   logic [63:0] prod_ff, cand_ff;
   assc_pkg::rsp_type rsp_ff;

   logic [32:0] sum_in;
   logic [1:0]  r_in, wr_idx_in;
   logic [63:0] opnd_in;
   logic [HIST_SEL_W-1:0] hsel_in;
   logic signed [15:0] lint_in;
   logic [assc_pkg::FRAC_W-1:0] lfrac_in;
   logic signed [63:0] lval_in, d_in;
   logic        neg_in;
   logic [63:0] mag_in;
   logic [31:0] coef_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] term_in;
   logic [95:0] full_in;
   logic [assc_pkg::FRAC_IDX_W-1:0] fidx_in;
   logic signed [15:0] n_in, nneg_in;
   logic [127:0] wide_in;
   logic [63:0] cand_in, d1_in, cap_in, next_in;
   logic        hmin_in, hmax_in;
   logic [31:0] minc_in, maxc_in;

   assign sum_in    = {1'b0, req_payload.steps_taken} + {1'b0, req_payload.rejections};
   assign r_in      = mod3_33(sum_in);
   assign wr_idx_in = add_mod3(r_in, 2'd2);

   always_comb begin
      case (cmd.opnd)
         2'd1:    hsel_in = add_mod3(r_ff, 2'd2);
         2'd2:    hsel_in = add_mod3(r_ff, 2'd1);
         default: hsel_in = r_ff;
      endcase
      if (cmd.opnd == 2'd0) opnd_in = tol_ff;
      else if (!pid_ff)     opnd_in = err_ff;
      else                  opnd_in = hist_ff[hsel_in];
   end

   always_comb begin
      if (!pid_ff) coef_in = assc_pkg::EXP_ONE_THIRD;
      else begin
         case (cmd.opnd)
            2'd1:    coef_in = assc_pkg::EXP_NEWEST;
            2'd2:    coef_in = assc_pkg::EXP_MIDDLE;
            default: coef_in = assc_pkg::EXP_OLDEST;
         endcase
      end
   end

   // log2 of the current operand, signed Q15.48
   assign lint_in  = 16'sd15 - $signed({10'd0, sh_ff});
   assign lfrac_in = assc_pkg::FRAC_W'(fbits_ff) << FRAC_SHIFT;
   assign lval_in  = $signed({lint_in, lfrac_in});
   assign d_in     = ltol_ff - lval_in;
   assign neg_in   = d_in[63];
   assign mag_in   = neg_in ? 64'(-d_in) : 64'(d_in);

   // shared 32x32 multiplier
   always_comb begin
      case (cmd.op)
         assc_pkg::OP_LOG_SQ:   begin mul_a = m_ff;           mul_b = m_ff;          end
         assc_pkg::OP_TERM_LO:  begin mul_a = mag_in[31:0];   mul_b = coef_in;       end
         assc_pkg::OP_TERM_HI:  begin mul_a = mag_in[63:32];  mul_b = coef_in;       end
         assc_pkg::OP_EXP_STEP: begin
            mul_a = acc_ff;
            mul_b = assc_pkg::ROOT_TABLE[cmd.iter];
         end
         assc_pkg::OP_PROD_LO:  begin mul_a = step_ff[31:0];  mul_b = acc_ff;        end
         assc_pkg::OP_PROD_HI:  begin mul_a = step_ff[63:32]; mul_b = acc_ff;        end
         assc_pkg::OP_SAFE_LO:  begin
            mul_a = prod_ff[31:0];
            mul_b = assc_pkg::SAFETY_FACTOR;
         end
         assc_pkg::OP_SAFE_HI:  begin
            mul_a = prod_ff[63:32];
            mul_b = assc_pkg::SAFETY_FACTOR;
         end
         default:               begin mul_a = 32'd0;          mul_b = 32'd0;         end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   assign term_in = mul_p + (pp_ff >> 32);
   assign full_in = {mul_p, 32'd0} + {32'd0, pp_ff};
   assign fidx_in = assc_pkg::FRAC_IDX_W'(assc_pkg::FRAC_W) - assc_pkg::FRAC_IDX_W'(cmd.iter);

   // scale by 2^n with saturation
   always_comb begin
      n_in    = $signed(e_ff[63:48]);
      nneg_in = -n_in;
      wide_in = {64'd0, prod_ff} << n_in[5:0];
      if (zero_ff)                  cand_in = assc_pkg::ALL_ONES;
      else if (tol_ff == 64'd0)     cand_in = 64'd0;
      else if (over_ff)             cand_in = assc_pkg::ALL_ONES;
      else if (n_in >= 16'sd64)     cand_in = (prod_ff == 64'd0) ? 64'd0 : assc_pkg::ALL_ONES;
      else if (n_in >= 16'sd0)      cand_in = (wide_in[127:64] != 64'd0) ?
                                              assc_pkg::ALL_ONES : wide_in[63:0];
      else if (n_in <= -16'sd64)    cand_in = 64'd0;
      else                          cand_in = prod_ff >> nneg_in[5:0];
   end

   // bound and count
   always_comb begin
      d1_in   = (cand_ff < max_ff) ? cand_ff : max_ff;
      cap_in  = (step_ff > assc_pkg::GROWTH_BOUND) ? assc_pkg::ALL_ONES
                                                   : (step_ff << 2) + step_ff;
      if (cap_in < d1_in) d1_in = cap_in;
      next_in = (d1_in < min_ff) ? min_ff : d1_in;
      hmin_in = (next_in == min_ff);
      hmax_in = !hmin_in && (next_in == max_ff);
      minc_in = minc_ff;
      maxc_in = maxc_ff;
      if (hmin_in && minc_ff != assc_pkg::COUNT_MAX) minc_in = minc_ff + 32'd1;
      if (hmax_in && maxc_ff != assc_pkg::COUNT_MAX) maxc_in = maxc_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         tol_ff     <= assc_pkg::TOL_RESET;
         min_ff     <= 64'd0;
         max_ff     <= assc_pkg::ALL_ONES;
         hist_ff[0] <= 64'd0;
         hist_ff[1] <= 64'd0;
         hist_ff[2] <= 64'd0;
         minc_ff    <= 32'd0;
         maxc_ff    <= 32'd0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               assc_pkg::REG_MODE: mode_ff <= csr_wdata[0];
               assc_pkg::REG_TOL:  tol_ff  <= csr_wdata;
               assc_pkg::REG_MIN:  min_ff  <= csr_wdata;
               assc_pkg::REG_MAX:  max_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.op == assc_pkg::OP_LOAD && mode_ff) hist_ff[wr_idx_in] <= req_payload.error_value;
         if (cmd.op == assc_pkg::OP_FINISH) begin
            minc_ff <= minc_in;
            maxc_ff <= maxc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         assc_pkg::OP_LOAD: begin
            err_ff  <= req_payload.error_value;
            step_ff <= req_payload.current_step;
            pid_ff  <= mode_ff && (req_payload.steps_taken >= assc_pkg::PID_START);
            r_ff    <= r_in;
            zero_ff <= 1'b0;
            e_ff    <= 64'sd0;
         end
         assc_pkg::OP_LOG_INIT: begin
            xn_ff <= opnd_in;
            sh_ff <= 6'd0;
            if (cmd.opnd != 2'd0 && opnd_in == 64'd0) zero_ff <= 1'b1;
         end
         assc_pkg::OP_NORM: begin
            // shift until bit 63 is set; the last pass takes the top word
            if (!sts.norm_done) begin
               // skip a whole zero byte when possible
               if (xn_ff[63:56] == 8'd0) begin
                  xn_ff <= xn_ff << 8;
                  sh_ff <= sh_ff + 6'd8;
               end else begin
                  xn_ff <= xn_ff << 1;
                  sh_ff <= sh_ff + 6'd1;
               end
            end
            m_ff <= xn_ff[63:32];
         end
         assc_pkg::OP_LOG_SQ: begin
            // all old bits are shifted out after LOG_ITERATIONS passes
            fbits_ff <= {fbits_ff[assc_pkg::LOG_ITERATIONS-2:0], mul_p[63]};
            m_ff     <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
         end
         assc_pkg::OP_TOL_SAVE: ltol_ff <= lval_in;
         assc_pkg::OP_TERM_LO:  pp_ff   <= mul_p;
         assc_pkg::OP_TERM_HI:  e_ff    <= neg_in ? e_ff - $signed(term_in)
                                                  : e_ff + $signed(term_in);
         assc_pkg::OP_EXP_INIT: acc_ff  <= 32'd1 << 30;
         assc_pkg::OP_EXP_STEP: if (e_ff[fidx_in]) acc_ff <= mul_p[61:30];
         assc_pkg::OP_PROD_LO:  pp_ff   <= mul_p;
         assc_pkg::OP_PROD_HI: begin
            over_ff <= (full_in[95:94] != 2'd0);
            prod_ff <= full_in[93:30];
         end
         assc_pkg::OP_SAFE_LO:  pp_ff   <= mul_p;
         assc_pkg::OP_SAFE_HI:  prod_ff <= term_in;
         assc_pkg::OP_SHIFT:    cand_ff <= cand_in;
         assc_pkg::OP_FINISH: begin
            rsp_ff.next_step    <= next_in;
            rsp_ff.hit_minimum  <= hmin_in;
            rsp_ff.hit_maximum  <= hmax_in;
            rsp_ff.minimum_hits <= minc_in;
            rsp_ff.maximum_hits <= maxc_in;
         end
         default: ;
      endcase
   end

   // normalized operand seen before its top word is taken into m
   always_comb begin
      sts.norm_done = xn_ff[63] || (xn_ff == 64'd0);
      sts.use_pid   = pid_ff;
   end

   assign rsp_payload = rsp_ff;

endmodule

### rtl/assc_ctrl.sv
// Controller: sequences log2, weighting, exp2, scaling and bounding of one item
`include "adaptive_step_size_controller_assert.svh"
module assc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  assc_pkg::sts_type sts,
   output assc_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOG_INIT, ST_NORM, ST_LOG_SQ, ST_LOG_USE, ST_TERM_HI,
      ST_EXP_INIT, ST_EXP_STEP, ST_PROD_LO, ST_PROD_HI, ST_SAFE_LO,
      ST_SAFE_HI, ST_SHIFT, ST_FINISH
   } state_type;

   localparam logic [assc_pkg::ITER_W-1:0] LAST_ITER = assc_pkg::ITER_W'(assc_pkg::LOG_ITERATIONS);

   state_type                     state_ff;
   logic [1:0]                    opnd_ff;
   logic [assc_pkg::ITER_W-1:0]   iter_ff;
   logic                          rsp_valid_ff;
   logic [1:0]                    last_opnd_in;

   assign last_opnd_in = sts.use_pid ? 2'd3 : 2'd1;
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      cmd.opnd = opnd_ff;
      cmd.iter = iter_ff;
      case (state_ff)
         ST_IDLE:     cmd.op = req_valid ? assc_pkg::OP_LOAD : assc_pkg::OP_NONE;
         ST_LOG_INIT: cmd.op = assc_pkg::OP_LOG_INIT;
         ST_NORM:     cmd.op = assc_pkg::OP_NORM;
         ST_LOG_SQ:   cmd.op = assc_pkg::OP_LOG_SQ;
         ST_LOG_USE:  cmd.op = (opnd_ff == 2'd0) ? assc_pkg::OP_TOL_SAVE
                                                 : assc_pkg::OP_TERM_LO;
         ST_TERM_HI:  cmd.op = assc_pkg::OP_TERM_HI;
         ST_EXP_INIT: cmd.op = assc_pkg::OP_EXP_INIT;
         ST_EXP_STEP: cmd.op = assc_pkg::OP_EXP_STEP;
         ST_PROD_LO:  cmd.op = assc_pkg::OP_PROD_LO;
         ST_PROD_HI:  cmd.op = assc_pkg::OP_PROD_HI;
         ST_SAFE_LO:  cmd.op = assc_pkg::OP_SAFE_LO;
         ST_SAFE_HI:  cmd.op = assc_pkg::OP_SAFE_HI;
         ST_SHIFT:    cmd.op = assc_pkg::OP_SHIFT;
         ST_FINISH:   cmd.op = (!rsp_valid_ff || !rsp_stall) ? assc_pkg::OP_FINISH
                                                             : assc_pkg::OP_NONE;
         default:     cmd.op = assc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         opnd_ff      <= 2'd0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == assc_pkg::OP_FINISH) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)               rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_valid) begin
               state_ff <= ST_LOG_INIT;
               opnd_ff  <= 2'd0;
            end
            ST_LOG_INIT: state_ff <= ST_NORM;
            ST_NORM: if (sts.norm_done) begin
               state_ff <= ST_LOG_SQ;
               iter_ff  <= assc_pkg::ITER_W'(1);
            end
            ST_LOG_SQ: begin
               if (iter_ff == LAST_ITER) state_ff <= ST_LOG_USE;
               else                      iter_ff  <= iter_ff + 1'b1;
            end
            ST_LOG_USE: begin
               if (opnd_ff == 2'd0) begin
                  opnd_ff  <= 2'd1;
                  state_ff <= ST_LOG_INIT;
               end else begin
                  state_ff <= ST_TERM_HI;
               end
            end
            ST_TERM_HI: begin
               if (opnd_ff == last_opnd_in) begin
                  state_ff <= ST_EXP_INIT;
               end else begin
                  opnd_ff  <= opnd_ff + 2'd1;
                  state_ff <= ST_LOG_INIT;
               end
            end
            ST_EXP_INIT: begin
               state_ff <= ST_EXP_STEP;
               iter_ff  <= assc_pkg::ITER_W'(1);
            end
            ST_EXP_STEP: begin
               if (iter_ff == LAST_ITER) state_ff <= ST_PROD_LO;
               else                      iter_ff  <= iter_ff + 1'b1;
            end
            ST_PROD_LO: state_ff <= ST_PROD_HI;
            ST_PROD_HI: state_ff <= ST_SAFE_LO;
            ST_SAFE_LO: state_ff <= ST_SAFE_HI;
            ST_SAFE_HI: state_ff <= ST_SHIFT;
            ST_SHIFT:   state_ff <= ST_FINISH;
            ST_FINISH:  if (!rsp_valid_ff || !rsp_stall) state_ff <= ST_IDLE;
            default:    state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSC_IMPLY(a_sq_range, clock, reset, state_ff == ST_LOG_SQ, iter_ff != '0 && iter_ff <= LAST_ITER)
   `ASSC_IMPLY(a_term_opnd, clock, reset, state_ff == ST_TERM_HI, opnd_ff != 2'd0)
   `ASSC_IMPLY(a_finish_free, clock, reset, cmd.op == assc_pkg::OP_FINISH, !rsp_valid_ff || !rsp_stall)
   `ASSC_NEXT(a_accept_start, clock, reset, req_valid && !req_stall, state_ff == ST_LOG_INIT && opnd_ff == 2'd0)

endmodule
